### rtl/sal_pkg.sv
// Shared types and constants of the sequential array list.
// Used by sal_cell, sal_chain and sequential_array_list_top; depends on nothing.
package sal_pkg;

  // Action codes carried by an input item.
  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_REM_FRONT = 3'd3,
    ACT_REM_BACK  = 3'd4,
    ACT_REM_AT    = 3'd5,
    ACT_READ_AT   = 3'd6
  } action_t;

  // Status codes carried by a result item.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Kind of work a decoded item asks of the chain.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2,
    OP_READ = 2'd3
  } op_kind_t;

  // Target index width, wide enough for the largest supported depth.
  localparam int TGT_W = 12;

  // Cells per group in the registered read-out tree.
  localparam int GROUP = 16;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [TGT_W-1:0] tgt;
  } cell_ctl_t;

endpackage

### rtl/sequential_array_list_top.sv
// Top level of the sequential array list: item decode, command register and result register.
// Depends on sal_pkg and sal_chain.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_action, in_position, in_entry_value
//  out      output     out_valid / out_stall out_status, out_result_value, out_count_now
//
// Each item is decoded on the accept edge, which also captures the first
// level of the read-out tree; the commit edge shifts the cell chain and loads the result.
// A result waiting under out_stall holds back the commit edge and further items.
// Reset clears the entry count and both valid flags; the cells keep their contents.
module sequential_array_list_top
  import sal_pkg::*;
#(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_position,
  input  logic [31:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_value,
  output logic [7:0]  out_count_now
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  logic                  accept;
  logic                  commit;
  logic [CW-1:0]         count_r;
  logic                  op_valid_r;
  op_kind_t              op_kind_r;
  logic [1:0]            op_status_r;
  logic [TGT_W-1:0]      op_tgt_r;
  logic [CW-1:0]         op_cnt_r;
  logic [DATA_WIDTH-1:0] op_val_r;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [31:0]           out_result_r;
  logic [7:0]            out_count_r;

  op_kind_t              dec_kind;
  logic [PW-1:0]         dec_tgt;
  logic [1:0]            dec_status;
  logic [CW-1:0]         dec_cnt;
  logic [PW-1:0]         cnt_p;
  logic [PW-1:0]         pos_p;
  logic [63:0]           ev_wide;
  logic [63:0]           rd_wide;
  logic [DATA_WIDTH-1:0] rd_value;
  cell_ctl_t             ctl;

  // Handshake: one item in flight, and none taken while a result is stuck.
  assign in_stall = op_valid_r | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign commit   = op_valid_r & (~out_valid_r | ~out_stall);

  assign cnt_p   = PW'(count_r);
  assign pos_p   = PW'(in_position);
  assign ev_wide = 64'(in_entry_value);

  // Decode the action into target position, kind of work and status.
  always_comb begin
    dec_kind   = OP_NONE;
    dec_tgt    = '0;
    dec_status = ST_BAD;
    dec_cnt    = count_r;
    case (action_t'(in_action))
      ACT_INS_FRONT: begin
        dec_kind = OP_INS;
        dec_tgt  = '0;
      end
      ACT_INS_BACK: begin
        dec_kind = OP_INS;
        dec_tgt  = cnt_p;
      end
      ACT_INS_AT: begin
        dec_kind = OP_INS;
        dec_tgt  = pos_p;
      end
      ACT_REM_FRONT: begin
        dec_kind = OP_REM;
        dec_tgt  = '0;
      end
      ACT_REM_BACK: begin
        dec_kind = OP_REM;
        dec_tgt  = cnt_p - 1'b1;
      end
      ACT_REM_AT: begin
        dec_kind = OP_REM;
        dec_tgt  = pos_p;
      end
      ACT_READ_AT: begin
        dec_kind = OP_READ;
        dec_tgt  = pos_p;
      end
      default: begin
        dec_kind = OP_NONE;
      end
    endcase

    case (dec_kind)
      OP_INS: begin
        if (cnt_p == DEPTH_P) begin
          dec_status = ST_FULL;
        end else if (dec_tgt > cnt_p) begin
          dec_status = ST_BAD;
        end else begin
          dec_status = ST_OK;
          dec_cnt    = count_r + 1'b1;
        end
      end
      OP_REM: begin
        if (cnt_p == '0 || dec_tgt >= cnt_p) begin
          dec_status = ST_BAD;
        end else begin
          dec_status = ST_OK;
          dec_cnt    = count_r - 1'b1;
        end
      end
      OP_READ: begin
        dec_status = (dec_tgt >= cnt_p) ? ST_BAD : ST_OK;
      end
      default: begin
        dec_status = ST_BAD;
      end
    endcase
  end

  // Control registers: pending command flag, entry count, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        op_valid_r <= 1'b1;
      end else if (commit) begin
        op_valid_r <= 1'b0;
      end
      if (commit) begin
        count_r     <= op_cnt_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command payload, captured with the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind_r   <= dec_kind;
      op_status_r <= dec_status;
      op_tgt_r    <= TGT_W'(dec_tgt);
      op_cnt_r    <= dec_cnt;
      op_val_r    <= ev_wide[DATA_WIDTH-1:0];
    end
  end

  // Shift command to the cells, only on the commit edge of a successful item.
  always_comb begin
    ctl.ins = commit && op_kind_r == OP_INS && op_status_r == ST_OK;
    ctl.rem = commit && op_kind_r == OP_REM && op_status_r == ST_OK;
    ctl.tgt = op_tgt_r;
  end

  sal_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .tap_tgt  (TGT_W'(dec_tgt)),
    .cap      (accept),
    .ins_val  (op_val_r),
    .rd_value (rd_value)
  );

  assign rd_wide = 64'(rd_value);

  // Result register: the entry is reported only by a successful remove or read.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r  <= op_status_r;
      out_count_r   <= 8'(op_cnt_r);
      if (op_status_r == ST_OK && (op_kind_r == OP_REM || op_kind_r == OP_READ)) begin
        out_result_r <= rd_wide[31:0];
      end else begin
        out_result_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_result_r;
  assign out_count_now    = out_count_r;

  // The entry count never passes the list depth.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    PW'(count_r) <= DEPTH_P)
    else $error("entry count beyond depth");

  // A successful insert grows the list by exactly one entry.
  a_ins_count : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count by one");

  // A successful remove shrinks the list by exactly one entry.
  a_rem_count : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not shrink the count by one");

  // A failed action never reports an entry.
  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_result_r == '0)
    else $error("failed item carries a nonzero entry");

endmodule

### rtl/sal_cell.sv
// One storage cell of the list chain: holds a single entry.
// Depends on sal_pkg for the broadcast command type.
module sal_cell
  import sal_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [TGT_W-1:0]      tap_tgt,
  input  logic [DATA_WIDTH-1:0] ins_val,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] tap
);

  localparam logic [TGT_W-1:0] MY_IDX = TGT_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Insert shifts cells above the target up; removal pulls cells from the target on down.
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX > ctl.tgt) begin
        data_nxt = left_data;
      end else if (MY_IDX == ctl.tgt) begin
        data_nxt = ins_val;
      end
    end else if (ctl.rem) begin
      if (MY_IDX >= ctl.tgt) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // The addressed cell puts its entry on the read-out tree; all others give zero.
  assign tap  = (MY_IDX == tap_tgt) ? data_r : '0;
  assign data = data_r;

endmodule

### rtl/sal_chain.sv
// Row of list cells with a registered OR tree that reads out one addressed entry.
// Depends on sal_pkg and sal_cell.
module sal_chain
  import sal_pkg::*;
#(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [TGT_W-1:0]      tap_tgt,
  input  logic                  cap,
  input  logic [DATA_WIDTH-1:0] ins_val,
  output logic [DATA_WIDTH-1:0] rd_value
);

  localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
  logic [DATA_WIDTH-1:0] part_r    [NGROUPS];
  logic [DATA_WIDTH-1:0] part_nxt  [NGROUPS];

  // The cells, each wired to its two neighbors; the ends see zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    sal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .tap_tgt    (tap_tgt),
      .ins_val    (ins_val),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // First tree level: OR of each group of taps, registered when an item is taken.
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          part_nxt[g] = part_nxt[g] | cell_tap[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      part_r <= part_nxt;
    end
  end

  // Second tree level: OR of the group results.
  always_comb begin
    rd_value = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      rd_value = rd_value | part_r[g];
    end
  end

endmodule
